### rtl/periodic_timer_table_assert.svh
// Assertion macros shared by the periodic timer table RTL.
// Expects i_clk and i_rst_n in the scope of the module that uses them.
`ifndef PERIODIC_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_TIMER_TABLE_ASSERT_SVH

// Clocked property check, off while reset is held.
`define PTT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Invariant that holds at every edge out of reset.
`define PTT_INVARIANT(label, expr, msg) \
    `PTT_ASSERT(label, 1'b1 |-> (expr), msg)

`endif

### rtl/ptt_pkg.sv
// Types and constants for the periodic timer table.
// No dependencies; imported by ptt_front, ptt_engine and the top level.
package ptt_pkg;

    localparam int SLOTS     = 16;
    localparam int TIME_BITS = 32;
    localparam int ID_BITS   = 8;

    // slot index and occupancy count widths
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    // command queue between front and engine, depth is a power of two
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_DEL  = 2'd1,
        OP_TICK = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        KIND_ADD  = 2'd0,
        KIND_DEL  = 2'd1,
        KIND_FIRE = 2'd2,
        KIND_TICK = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] period;
        logic [7:0]  task_id;
        logic        to_queue;
        logic [31:0] elapsed;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  fired_task;
        logic        fired_to_queue;
        logic        accepted;
        logic [4:0]  deleted_count;
        logic [31:0] min_remaining;
        logic        last;
    } t_out_item;

    // classified command; amount is the period for add, elapsed for tick
    typedef struct packed {
        t_op                  op;
        logic [TIME_BITS-1:0] amount;
        logic [ID_BITS-1:0]   task_id;
        logic                 to_queue;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_ch;

endpackage

### rtl/ptt_front.sv
// Input side of the periodic timer table: accepts transactions, drops
// unknown operations and queues commands for the engine. Uses ptt_pkg.
module ptt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ptt_pkg::t_in_item i_in_item,
    output ptt_pkg::t_cmd_ch  o_cmd,
    input  logic              i_cmd_pop
);
    import ptt_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;

    logic is_cmd;
    t_cmd cmd;
    logic push;
    logic pop;

    always_comb begin
        is_cmd       = 1'b1;
        cmd.op       = OP_ADD;
        cmd.amount   = TIME_BITS'(i_in_item.period);
        cmd.task_id  = ID_BITS'(i_in_item.task_id);
        cmd.to_queue = i_in_item.to_queue;
        case (i_in_item.operation)
            OP_ADD:  cmd.op = OP_ADD;
            OP_DEL:  cmd.op = OP_DEL;
            OP_TICK: begin
                cmd.op     = OP_TICK;
                cmd.amount = TIME_BITS'(i_in_item.elapsed);
            end
            default: is_cmd = 1'b0;   // unknown op: accepted, no effect
        endcase
    end

    assign o_in_ready = (r_cnt != QCNT_W'(QDEPTH));
    assign push       = i_in_valid && o_in_ready && is_cmd;
    assign pop        = i_cmd_pop && (r_cnt != '0);

    assign o_cmd.valid = (r_cnt != '0);
    assign o_cmd.cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### rtl/ptt_engine.sv
// Timer table engine: slot storage, add/delete/tick walk and output register.
// Uses ptt_pkg and the assertion macros in periodic_timer_table_assert.svh.
`include "periodic_timer_table_assert.svh"

module ptt_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ptt_pkg::t_cmd_ch   i_cmd,
    output logic               o_cmd_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ptt_pkg::t_out_item o_out_item
);
    import ptt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINAL
    } t_state;

    // slot table; occupied slots are the prefix [0, r_count)
    logic [TIME_BITS-1:0] r_per  [SLOTS];
    logic [TIME_BITS-1:0] r_rem  [SLOTS];
    logic [ID_BITS-1:0]   r_task [SLOTS];
    logic                 r_qf   [SLOTS];

    t_state               r_state;
    t_cmd                 r_cmd;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_idx;
    logic [CNT_W-1:0]     r_removed;
    logic [TIME_BITS-1:0] r_min;
    logic                 r_acc;
    logic                 r_out_valid;
    t_out_item            r_out_item;

    logic [IDX_W-1:0]     rd_idx;
    logic [TIME_BITS-1:0] cur_per;
    logic [TIME_BITS-1:0] cur_rem;
    logic [ID_BITS-1:0]   cur_task;
    logic                 cur_q;
    logic                 at_end;
    logic                 fire;
    logic [TIME_BITS-1:0] new_rem;
    logic                 match;
    logic                 out_free;
    logic                 step;
    logic                 final_go;
    logic                 add_ok;
    logic [CNT_W-1:0]     dst;

    logic                 n_out_valid;
    t_out_item            n_out_item;

    logic                 w_en;
    logic [IDX_W-1:0]     w_addr;
    logic [TIME_BITS-1:0] w_per;
    logic [TIME_BITS-1:0] w_rem;
    logic [ID_BITS-1:0]   w_task;
    logic                 w_q;

    always_comb begin
        rd_idx   = r_idx[IDX_W-1:0];
        cur_per  = r_per[rd_idx];
        cur_rem  = r_rem[rd_idx];
        cur_task = r_task[rd_idx];
        cur_q    = r_qf[rd_idx];
        at_end   = (r_idx == r_count);
        fire     = (cur_rem <= r_cmd.amount);
        new_rem  = fire ? cur_per : (cur_rem - r_cmd.amount);
        match    = (cur_task == r_cmd.task_id);
        out_free = !r_out_valid || i_out_ready;
        // a firing slot waits for the output register
        step     = (r_state == ST_WALK) && !at_end &&
                   ((r_cmd.op != OP_TICK) || !fire || out_free);
        final_go = (r_state == ST_FINAL) && out_free;
        add_ok   = (i_cmd.cmd.amount != '0) && (r_count < CNT_W'(SLOTS));
        dst      = r_idx - r_removed;
    end

    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd.valid;

    // single write port into the slot table
    always_comb begin
        w_en   = 1'b0;
        w_addr = rd_idx;
        w_per  = cur_per;
        w_rem  = new_rem;
        w_task = cur_task;
        w_q    = cur_q;
        if (o_cmd_pop && (i_cmd.cmd.op == OP_ADD) && add_ok) begin
            w_en   = 1'b1;
            w_addr = r_count[IDX_W-1:0];
            w_per  = i_cmd.cmd.amount;
            w_rem  = i_cmd.cmd.amount;
            w_task = i_cmd.cmd.task_id;
            w_q    = i_cmd.cmd.to_queue;
        end else if (step && (r_cmd.op == OP_TICK)) begin
            w_en = 1'b1;
        end else if (step && (r_cmd.op == OP_DEL) && !match && (r_removed != '0)) begin
            // compact: move survivor up over the removed slots
            w_en   = 1'b1;
            w_addr = dst[IDX_W-1:0];
            w_rem  = cur_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_per[w_addr]  <= w_per;
            r_rem[w_addr]  <= w_rem;
            r_task[w_addr] <= w_task;
            r_qf[w_addr]   <= w_q;
        end
    end

    // next output register contents: fire results during the walk, then the final
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;
        if (step && (r_cmd.op == OP_TICK) && fire) begin
            n_out_valid               = 1'b1;
            n_out_item                = '0;
            n_out_item.kind           = KIND_FIRE;
            n_out_item.fired_task     = 8'(cur_task);
            n_out_item.fired_to_queue = cur_q;
        end else if (final_go) begin
            n_out_valid     = 1'b1;
            n_out_item      = '0;
            n_out_item.last = 1'b1;
            case (r_cmd.op)
                OP_ADD: begin
                    n_out_item.kind     = KIND_ADD;
                    n_out_item.accepted = r_acc;
                end
                OP_DEL: begin
                    n_out_item.kind          = KIND_DEL;
                    n_out_item.deleted_count = 5'(r_removed);
                end
                default: begin
                    n_out_item.kind          = KIND_TICK;
                    n_out_item.min_remaining = 32'(r_min);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_out_item  <= n_out_item;
            case (r_state)
                ST_IDLE: begin
                    if (o_cmd_pop) begin
                        r_cmd     <= i_cmd.cmd;
                        r_idx     <= '0;
                        r_removed <= '0;
                        r_min     <= '0;
                        r_acc     <= add_ok;
                        if (i_cmd.cmd.op == OP_ADD) begin
                            if (add_ok) begin
                                r_count <= r_count + CNT_W'(1);
                            end
                            r_state <= ST_FINAL;
                        end else begin
                            r_state <= ST_WALK;
                        end
                    end
                end
                ST_WALK: begin
                    if (at_end) begin
                        r_state <= ST_FINAL;
                    end else if (step) begin
                        r_idx <= r_idx + CNT_W'(1);
                        case (r_cmd.op)
                            OP_TICK: begin
                                if ((r_min == '0) || (new_rem < r_min)) begin
                                    r_min <= new_rem;
                                end
                            end
                            OP_DEL: begin
                                if (match) begin
                                    r_removed <= r_removed + CNT_W'(1);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_FINAL: begin
                    if (final_go) begin
                        if (r_cmd.op == OP_DEL) begin
                            r_count <= r_count - r_removed;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `PTT_INVARIANT(a_count_bound, r_count <= CNT_W'(SLOTS), "slot count above table size")
    `PTT_ASSERT(a_idx_bound, r_state == ST_WALK |-> r_idx <= r_count, "walk index past table")
    `PTT_ASSERT(a_final_last, final_go |=> (r_state == ST_IDLE) && r_out_item.last, "final not last")
    `PTT_ASSERT(a_final_valid, final_go |=> r_out_valid, "final result not valid")
    `PTT_ASSERT(a_del_count, final_go && (r_cmd.op == OP_DEL) |=> r_count == $past(dst), "bad count")

endmodule

### rtl/periodic_timer_table.sv
// Add goes straight to the final state; delete and tick first walk the N
// occupied slots (N at most SLOTS = 16), then give the final result.
// Throughput: one slot per cycle through the engine walk; a fire result
// holds the walk while the output register is full. Up to 2 commands queue.
// Reset (synchronous, active low) empties the table, queue and output
// register; no clearing pass.
module periodic_timer_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ptt_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ptt_pkg::t_out_item o_out_item
);
    import ptt_pkg::*;

    t_cmd_ch cmd_ch;
    logic    cmd_pop;

    ptt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_cmd      (cmd_ch),
        .i_cmd_pop  (cmd_pop)
    );

    ptt_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_ch),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

### sim/tb.sv
// Testbench for periodic_timer_table: directed then random add, delete and tick
// transactions, with every result checked against a behavioral timer table.
// Depends on ptt_pkg and the periodic_timer_table RTL.
module tb;
    import ptt_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    // window of cycles with no idling on either side
    localparam int CALM_FROM = 600;
    localparam int CALM_TO   = 1400;

    typedef struct packed {
        logic     drain_first;
        t_in_item item;
    } t_stim;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    t_stim     stim_q[$];
    t_out_item want_q[$];
    int        err_count = 0;
    int        cyc = 0;

    // predicted timer table
    logic [TIME_BITS-1:0] tbl_period [SLOTS];
    logic [TIME_BITS-1:0] tbl_left   [SLOTS];
    logic [ID_BITS-1:0]   tbl_task   [SLOTS];
    logic                 tbl_queue  [SLOTS];

    periodic_timer_table DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    // Update the predicted table for one accepted transaction and queue the
    // results it should produce.
    task automatic table_step(input t_in_item it);
        t_out_item            r;
        t_out_item            f;
        int                   i;
        int                   w;
        int                   hits;
        logic [TIME_BITS-1:0] least;
        r = '0;
        r.last = 1'b1;
        case (it.operation)
            OP_ADD: begin
                r.kind = KIND_ADD;
                if (it.period != 0) begin
                    for (i = 0; i < SLOTS; i++) begin
                        if (tbl_period[i] == 0) begin
                            tbl_period[i] = it.period;
                            tbl_left[i]   = it.period;
                            tbl_task[i]   = it.task_id;
                            tbl_queue[i]  = it.to_queue;
                            r.accepted    = 1'b1;
                            break;
                        end
                    end
                end
                want_q.push_back(r);
            end
            OP_DEL: begin
                w = 0;
                hits = 0;
                // compact the survivors toward slot 0, keeping their order
                for (i = 0; i < SLOTS; i++) begin
                    if (tbl_period[i] == 0)
                        break;
                    if (tbl_task[i] == it.task_id) begin
                        hits++;
                    end else begin
                        tbl_period[w] = tbl_period[i];
                        tbl_left[w]   = tbl_left[i];
                        tbl_task[w]   = tbl_task[i];
                        tbl_queue[w]  = tbl_queue[i];
                        w++;
                    end
                end
                for (i = w; i < w + hits; i++)
                    tbl_period[i] = '0;
                r.kind = KIND_DEL;
                r.deleted_count = 5'(hits);
                want_q.push_back(r);
            end
            OP_TICK: begin
                least = '0;
                for (i = 0; i < SLOTS; i++) begin
                    if (tbl_period[i] == 0)
                        break;
                    if (tbl_left[i] > it.elapsed) begin
                        tbl_left[i] = tbl_left[i] - it.elapsed;
                    end else begin
                        tbl_left[i] = tbl_period[i];
                        f = '0;
                        f.kind = KIND_FIRE;
                        f.fired_task = tbl_task[i];
                        f.fired_to_queue = tbl_queue[i];
                        want_q.push_back(f);
                    end
                    if (least == 0 || tbl_left[i] < least)
                        least = tbl_left[i];
                end
                r.kind = KIND_TICK;
                r.min_remaining = least;
                want_q.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic queue_item(input logic [1:0] op, input logic [31:0] period,
                              input logic [7:0] id, input logic q,
                              input logic [31:0] elapsed, input logic drain);
        t_stim s;
        s.drain_first = drain;
        s.item.operation = op;
        s.item.period = period;
        s.item.task_id = id;
        s.item.to_queue = q;
        s.item.elapsed = elapsed;
        stim_q.push_back(s);
    endtask

    // driver
    always @(posedge i_clk) begin : drv
        logic  fetch;
        t_stim nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                table_step(i_in_item);
            if (!i_in_valid || o_in_ready) begin
                fetch = stim_q.size() != 0 &&
                        ((cyc >= CALM_FROM && cyc < CALM_TO) || $urandom_range(99) >= 20);
                // hold off until every outstanding result is back
                if (fetch && stim_q[0].drain_first && want_q.size() != 0)
                    fetch = 1'b0;
                if (fetch) begin
                    nxt = stim_q.pop_front();
                    i_in_item <= nxt.item;
                end
                i_in_valid <= fetch;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : mon
        t_out_item w;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (want_q.size() == 0) begin
                    $error("unexpected result, kind %0d", o_out_item.kind);
                    err_count++;
                end else begin
                    w = want_q.pop_front();
                    if (o_out_item.kind !== w.kind) begin
                        $error("kind: expected %0d, got %0d", w.kind, o_out_item.kind);
                        err_count++;
                    end
                    if (o_out_item.fired_task !== w.fired_task) begin
                        $error("fired_task: expected %0d, got %0d",
                               w.fired_task, o_out_item.fired_task);
                        err_count++;
                    end
                    if (o_out_item.fired_to_queue !== w.fired_to_queue) begin
                        $error("fired_to_queue: expected %0d, got %0d",
                               w.fired_to_queue, o_out_item.fired_to_queue);
                        err_count++;
                    end
                    if (o_out_item.accepted !== w.accepted) begin
                        $error("accepted: expected %0d, got %0d",
                               w.accepted, o_out_item.accepted);
                        err_count++;
                    end
                    if (o_out_item.deleted_count !== w.deleted_count) begin
                        $error("deleted_count: expected %0d, got %0d",
                               w.deleted_count, o_out_item.deleted_count);
                        err_count++;
                    end
                    if (o_out_item.min_remaining !== w.min_remaining) begin
                        $error("min_remaining: expected %0d, got %0d",
                               w.min_remaining, o_out_item.min_remaining);
                        err_count++;
                    end
                    if (o_out_item.last !== w.last) begin
                        $error("last: expected %0d, got %0d", w.last, o_out_item.last);
                        err_count++;
                    end
                end
            end
            i_out_ready <= (cyc >= CALM_FROM && cyc < CALM_TO) || $urandom_range(99) >= 20;
        end
    end

    initial begin
        #2400000;
        $display("tb: errors");
        $finish;
    end

    initial begin : stim
        int          k;
        int          made;
        int          sel;
        int          r;
        logic [31:0] per;
        logic [31:0] ela;
        logic [7:0]  id;
        for (k = 0; k < SLOTS; k++) begin
            tbl_period[k] = '0;
            tbl_left[k]   = '0;
            tbl_task[k]   = '0;
            tbl_queue[k]  = 1'b0;
        end

        // directed: empty table, extremes, zero cases, full table, shifting delete
        queue_item(OP_TICK, 32'd0, 8'd0, 1'b0, 32'd5, 1'b0);
        queue_item(OP_ADD, 32'd0, 8'd3, 1'b1, 32'd0, 1'b0);
        queue_item(OP_ADD, 32'hFFFF_FFFF, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b0);
        queue_item(OP_ADD, 32'd1, 8'd0, 1'b0, 32'd0, 1'b0);
        queue_item(OP_ADD, 32'd3, 8'd7, 1'b1, 32'd0, 1'b0);
        queue_item(OP_TICK, 32'd0, 8'd0, 1'b0, 32'd0, 1'b0);
        queue_item(OP_TICK, 32'hFFFF_FFFF, 8'hFF, 1'b1, 32'd1, 1'b0);
        queue_item(OP_TICK, 32'd0, 8'd0, 1'b0, 32'hFFFF_FFFF, 1'b0);
        queue_item(OP_NONE, $urandom, 8'($urandom), 1'b1, $urandom, 1'b0);
        queue_item(OP_DEL, 32'd0, 8'd99, 1'b0, 32'd0, 1'b0);
        for (k = 0; k < 13; k++)
            queue_item(OP_ADD, 32'(k + 2), (k % 3 == 0) ? 8'd7 : 8'(k + 20),
                       1'(k), 32'd0, 1'b0);
        queue_item(OP_ADD, 32'd9, 8'd50, 1'b1, 32'd0, 1'b0);
        queue_item(OP_DEL, 32'd0, 8'd7, 1'b0, 32'd0, 1'b1);
        queue_item(OP_TICK, 32'd0, 8'd0, 1'b0, 32'd2, 1'b0);

        // random: small periods and ids dominate so timers fire and deletes hit
        made = 0;
        while (made < 75) begin
            sel = $urandom_range(99);
            r = $urandom_range(99);
            per = $urandom;
            ela = $urandom;
            id = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
            if (sel < 5) begin
                queue_item(OP_NONE, per, id, 1'($urandom), ela, 1'b0);
            end else begin
                made++;
                if (sel < 45) begin
                    if (r < 70)
                        per = $urandom_range(24, 1);
                    else if (r < 80)
                        per = '0;
                    queue_item(OP_ADD, per, id, 1'($urandom), ela, made == 50);
                end else if (sel < 60) begin
                    queue_item(OP_DEL, per, id, 1'($urandom), ela, made == 50);
                end else begin
                    if (r < 70)
                        ela = $urandom_range(8, 1);
                    else if (r < 78)
                        ela = '0;
                    else if (r < 85)
                        ela = 32'hFFFF_FFFF;
                    queue_item(OP_TICK, per, id, 1'($urandom), ela, made == 50);
                end
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (want_q.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/ptt_pkg.sv
rtl/ptt_front.sv
rtl/ptt_engine.sv
rtl/periodic_timer_table.sv
sim/tb.sv
